[rtl/csh_pkg.sv]
// Shared types, register codes and helper functions for the census stereo cost block.
// No dependencies; imported by csh_census, csh_emit and the top module.
`default_nettype none

package csh_pkg;

  // configuration register indexes
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [1:0] REG_DISPARITIES  = 2'd2;

  localparam logic [10:0] RESET_WIDTH       = 11'd640;
  localparam logic [10:0] RESET_HEIGHT      = 11'd480;
  localparam logic [6:0]  RESET_DISPARITIES = 7'd64;

  localparam int HEIGHT_LIMIT = 1024;
  localparam int CMP_W        = 14;  // compare width for clamps and counters

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINE,
    ST_EMIT
  } csh_state_t;

  // per-pixel request from the raster front end to the cost emitter
  typedef struct packed {
    logic       hist_we;    // store right code in the history
    logic       row_start;  // first column of a row: history pointer restarts
    logic [7:0] rcode;
    logic       start;      // emit costs for this centre
    logic [7:0] maxk;
    logic [7:0] lcode;
    logic [9:0] row;
    logic [9:0] col;
  } csh_job_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] col;
    logic [5:0] disp;
    logic [3:0] cost;
    logic       last;
  } csh_res_t;

  function automatic logic [3:0] popcount8(input logic [7:0] x);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) n = n + {3'b000, x[i]};
    return n;
  endfunction

endpackage

`default_nettype wire

[rtl/csh_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module csh_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic                                     re,
  input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[rtl/csh_census.sv]
// 3x3 census code of one window: bit set when neighbor >= center, clockwise from up.
// Uses csh_pkg.
`default_nettype none

module csh_census import csh_pkg::*; #(
  parameter int PW = 8
) (
  input  wire logic [PW-1:0] win [6],  // col c-2 (t,m,b), col c-1 (t,m,b)
  input  wire logic [PW-1:0] col [3],  // col c (t,m,b)
  output logic      [7:0]    code
);

  logic [PW-1:0] nb [8];
  logic [PW-1:0] ctr;

  always_comb begin
    ctr   = win[4];
    nb[0] = win[3];
    nb[1] = col[0];
    nb[2] = col[1];
    nb[3] = col[2];
    nb[4] = win[5];
    nb[5] = win[2];
    nb[6] = win[1];
    nb[7] = win[0];
    for (int k = 0; k < 8; k++) code[k] = (nb[k] >= ctr);
  end

endmodule

`default_nettype wire

[rtl/csh_emit.sv]
// Cost emitter: right code history RAM, read sequencer, output register and skid stage.
// Uses csh_pkg and csh_ram.
`default_nettype none

module csh_emit import csh_pkg::*; #(
  parameter int MAX_DISPARITY = 64
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire csh_job_t   job,
  output logic            busy,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [9:0]      centre_row,
  output logic [9:0]      centre_column,
  output logic [5:0]      disparity,
  output logic [3:0]      match_cost,
  output logic            last_of_pixel
);

  localparam int AW = (MAX_DISPARITY > 1) ? $clog2(MAX_DISPARITY) : 1;
  localparam logic [AW-1:0] TOP = AW'(MAX_DISPARITY - 1);

  logic [AW-1:0] wp, rptr, base, base_inc;
  logic [7:0]    k, maxk_q, pk;
  logic [7:0]    lcode_q, hist_rdata;
  logic [9:0]    row_q, col_q;
  logic          issuing, issue, pf, plast, take;
  logic          ov, sv;
  logic [1:0]    occ;
  csh_res_t      out_q, skid_q, arr;

  assign base     = job.row_start ? '0 : wp;
  assign base_inc = (base == TOP) ? '0 : base + AW'(1);

  csh_ram #(.WIDTH(8), .DEPTH(MAX_DISPARITY)) u_hist (
    .clk   (clk),
    .we    (job.hist_we),
    .waddr (base),
    .wdata (job.rcode),
    .re    (issue),
    .raddr (rptr),
    .rdata (hist_rdata)
  );

  // slots: output register, skid, read in flight
  assign take  = ov && out_ready;
  assign occ   = {1'b0, ov} + {1'b0, sv} + {1'b0, pf} - {1'b0, take};
  assign issue = issuing && (occ <= 2'd1);
  assign busy  = issuing || pf;

  always_comb begin
    arr.row  = row_q;
    arr.col  = col_q;
    arr.disp = pk[5:0];
    arr.cost = popcount8(lcode_q ^ hist_rdata);
    arr.last = plast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp      <= '0;
      issuing <= 1'b0;
      pf      <= 1'b0;
      ov      <= 1'b0;
      sv      <= 1'b0;
    end else begin
      if (job.hist_we) wp <= base_inc;
      if (job.start) begin
        rptr    <= base;
        k       <= '0;
        issuing <= 1'b1;
        maxk_q  <= job.maxk;
        lcode_q <= job.lcode;
        row_q   <= job.row;
        col_q   <= job.col;
      end else if (issue) begin
        rptr <= (rptr == '0) ? TOP : rptr - AW'(1);
        k    <= k + 8'd1;
        if (k == maxk_q) issuing <= 1'b0;
      end
      pf <= issue;
      if (issue) begin
        pk    <= k;
        plast <= (k == maxk_q);
      end
      if (!ov || take) begin
        if (sv) begin
          out_q <= skid_q;
          ov    <= 1'b1;
          if (pf) skid_q <= arr;
          else    sv     <= 1'b0;
        end else if (pf) begin
          out_q <= arr;
          ov    <= 1'b1;
        end else begin
          ov <= 1'b0;
        end
      end else if (pf) begin
        skid_q <= arr;
        sv     <= 1'b1;
      end
    end
  end

  assign out_valid     = ov;
  assign centre_row    = out_q.row;
  assign centre_column = out_q.col;
  assign disparity     = out_q.disp;
  assign match_cost    = out_q.cost;
  assign last_of_pixel = out_q.last;

endmodule

`default_nettype wire

[rtl/census_hamming_stereo_cost_top.sv]
// Census 3x3 transform with Hamming stereo cost. Per pixel: a line RAM read, then
// window/census/write-back; interior pixels then stream min(col,disp-1)+1 costs at
// one per cycle from the history RAM, set by its single read port, while the output
// does not stall, then the last read drains to idle. Reset: synchronous, active
// high; counters and windows cleared, registers 640/480/64, RAM contents undefined.
// Uses csh_pkg, csh_ram, csh_census, csh_emit.
`default_nettype none

module census_hamming_stereo_cost_top import csh_pkg::*; #(
  parameter int MAX_WIDTH     = 1024,
  parameter int MAX_DISPARITY = 64,
  parameter int PIXEL_BITS    = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [10:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  left_pixel,
  input  wire logic [7:0]  right_pixel,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [9:0]       centre_row,
  output logic [9:0]       centre_column,
  output logic [5:0]       disparity,
  output logic [3:0]       match_cost,
  output logic             last_of_pixel
);

  localparam int PW = (PIXEL_BITS < 8) ? PIXEL_BITS : 8;
  localparam int CW = $clog2(MAX_WIDTH);

  csh_state_t state, state_next;

  logic [10:0]    width_reg, height_reg;
  logic [6:0]     disp_reg;
  logic [CMP_W-1:0] w_eff, h_eff, d_eff, wx, hx, dx;
  logic [9:0]     r;
  logic [CW-1:0]  c;
  logic [PW-1:0]  lp_q, rp_q;
  logic [PW-1:0]  lwin [6];
  logic [PW-1:0]  rwin [6];
  logic [PW-1:0]  lcol [3];
  logic [PW-1:0]  rcol [3];
  logic [PW-1:0]  l0, l1, r0, r1;
  logic [4*PW-1:0] line_rdata, line_wdata;
  logic           line_re, line_we;
  logic [7:0]     lcode, rcode;
  logic           active, row_start, emit_busy;
  logic [CMP_W-1:0] jx, dm1, maxk_x, c_inc;
  logic [9:0]     r_inc;
  csh_job_t       job;

  // register clamps
  always_comb begin
    wx    = CMP_W'(width_reg);
    hx    = CMP_W'(height_reg);
    dx    = CMP_W'(disp_reg);
    w_eff = (wx < CMP_W'(3)) ? CMP_W'(3) :
            (wx > CMP_W'(MAX_WIDTH)) ? CMP_W'(MAX_WIDTH) : wx;
    h_eff = (hx < CMP_W'(3)) ? CMP_W'(3) :
            (hx > CMP_W'(HEIGHT_LIMIT)) ? CMP_W'(HEIGHT_LIMIT) : hx;
    d_eff = (dx < CMP_W'(1)) ? CMP_W'(1) :
            (dx > CMP_W'(MAX_DISPARITY)) ? CMP_W'(MAX_DISPARITY) : dx;
  end

  // line RAM entry per column: {right slot1, right slot0, left slot1, left slot0}
  csh_ram #(.WIDTH(4 * PW), .DEPTH(MAX_WIDTH)) u_line (
    .clk   (clk),
    .we    (line_we),
    .waddr (c),
    .wdata (line_wdata),
    .re    (line_re),
    .raddr (c),
    .rdata (line_rdata)
  );

  always_comb begin
    l0 = line_rdata[PW-1:0];
    l1 = line_rdata[2*PW-1:PW];
    r0 = line_rdata[3*PW-1:2*PW];
    r1 = line_rdata[4*PW-1:3*PW];
    // slot r&1 holds the top row, the other the middle row
    lcol[0] = r[0] ? l1 : l0;
    lcol[1] = r[0] ? l0 : l1;
    lcol[2] = lp_q;
    rcol[0] = r[0] ? r1 : r0;
    rcol[1] = r[0] ? r0 : r1;
    rcol[2] = rp_q;
    line_wdata = r[0] ? {rp_q, r0, lp_q, l0} : {r1, rp_q, l1, lp_q};
  end

  csh_census #(.PW(PW)) u_lcensus (.win(lwin), .col(lcol), .code(lcode));
  csh_census #(.PW(PW)) u_rcensus (.win(rwin), .col(rcol), .code(rcode));

  always_comb begin
    active    = (r >= 10'd2) && (c != '0);
    row_start = (c == CW'(1));
    jx        = CMP_W'(c) - CMP_W'(1);
    dm1       = d_eff - CMP_W'(1);
    maxk_x    = (jx < dm1) ? jx : dm1;
    c_inc     = CMP_W'(c) + CMP_W'(1);
    r_inc     = r + 10'd1;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (in_valid) state_next = ST_LINE;
      ST_LINE: state_next = (active && !row_start) ? ST_EMIT : ST_IDLE;
      ST_EMIT: if (!emit_busy) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    in_ready      = 1'b0;
    line_re       = 1'b0;
    line_we       = 1'b0;
    job.hist_we   = 1'b0;
    job.row_start = row_start;
    job.rcode     = row_start ? 8'd0 : rcode;
    job.start     = 1'b0;
    job.maxk      = maxk_x[7:0];
    job.lcode     = lcode;
    job.row       = r - 10'd1;
    job.col       = jx[9:0];
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        line_re  = in_valid;
      end
      ST_LINE: begin
        line_we     = 1'b1;
        job.hist_we = active;
        job.start   = active && !row_start;
      end
      ST_EMIT: ;
      default: ;
    endcase
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      width_reg  <= RESET_WIDTH;
      height_reg <= RESET_HEIGHT;
      disp_reg   <= RESET_DISPARITIES;
      r          <= '0;
      c          <= '0;
      for (int i = 0; i < 6; i++) begin
        lwin[i] <= '0;
        rwin[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (state == ST_LINE) begin
        for (int i = 0; i < 3; i++) begin
          lwin[i]     <= lwin[i+3];
          rwin[i]     <= rwin[i+3];
          lwin[i+3]   <= lcol[i];
          rwin[i+3]   <= rcol[i];
        end
        if (c_inc >= w_eff) begin
          c <= '0;
          r <= (CMP_W'(r_inc) >= h_eff) ? 10'd0 : r_inc;
        end else begin
          c <= c_inc[CW-1:0];
        end
      end
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_IMAGE_WIDTH:  width_reg  <= cfg_data;
          REG_IMAGE_HEIGHT: height_reg <= cfg_data;
          REG_DISPARITIES:  disp_reg   <= cfg_data[6:0];
          default: ;
        endcase
        // any listed register write restarts the frame
        if (cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT ||
            cfg_index == REG_DISPARITIES) begin
          r <= '0;
          c <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      lp_q <= left_pixel[PW-1:0];
      rp_q <= right_pixel[PW-1:0];
    end
  end

  csh_emit #(.MAX_DISPARITY(MAX_DISPARITY)) u_emit (
    .clk           (clk),
    .rst           (rst),
    .job           (job),
    .busy          (emit_busy),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .centre_row    (centre_row),
    .centre_column (centre_column),
    .disparity     (disparity),
    .match_cost    (match_cost),
    .last_of_pixel (last_of_pixel)
  );

endmodule

`default_nettype wire

[tb/csh_cost_scoreboard_pkg.sv]
// Cost scoreboard for the census stereo cost testbench: a bit-exact predictor of
// the cost stream plus the queue of costs the block still owes.
// Depends on csh_pkg for the result layout and register codes.
package csh_cost_scoreboard_pkg;
  import csh_pkg::*;

  localparam int LINE_MAX    = 1024;
  localparam int DISP_MAX    = 64;
  localparam int ROWS_MAX    = 1024;
  localparam int MAX_REPORTS = 20;

  class cost_scoreboard;
    logic [10:0] width_reg;
    logic [10:0] height_reg;
    logic [6:0]  disp_reg;
    logic [7:0]  left_rows [2][LINE_MAX];
    logic [7:0]  right_rows [2][LINE_MAX];
    logic [7:0]  left_win [6];
    logic [7:0]  right_win [6];
    logic [7:0]  right_codes [DISP_MAX];
    int unsigned row;
    int unsigned col;
    csh_res_t    pending_costs [$];
    int          errors;

    function new();
      width_reg  = RESET_WIDTH;
      height_reg = RESET_HEIGHT;
      disp_reg   = RESET_DISPARITIES;
      foreach (left_rows[s, c]) begin
        left_rows[s][c]  = '0;
        right_rows[s][c] = '0;
      end
      foreach (left_win[i]) begin
        left_win[i]  = '0;
        right_win[i] = '0;
      end
      foreach (right_codes[i]) right_codes[i] = '0;
      row    = 0;
      col    = 0;
      errors = 0;
    endfunction

    function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
      if (v < lo) return lo;
      if (v > hi) return hi;
      return v;
    endfunction

    // win: column c-2 (top, mid, bottom) then column c-1; cur: column c
    function logic [7:0] census_code(logic [7:0] win [6], logic [7:0] cur [3]);
      logic [7:0] nb [8];
      logic [7:0] code;
      nb = '{win[3], cur[0], cur[1], cur[2], win[5], win[2], win[1], win[0]};
      code = '0;
      for (int k = 0; k < 8; k++) code[k] = (nb[k] >= win[4]);
      return code;
    endfunction

    // any known register write restarts the frame; stores are kept
    function void write_reg(logic [1:0] idx, logic [10:0] data);
      case (idx)
        REG_IMAGE_WIDTH:  width_reg = data;
        REG_IMAGE_HEIGHT: height_reg = data;
        REG_DISPARITIES:  disp_reg = data[6:0];
        default: return;
      endcase
      row = 0;
      col = 0;
    endfunction

    function void note_pixel(logic [7:0] lp, logic [7:0] rp);
      int unsigned w, h, d, r, c, j, k, maxk, top, mid;
      logic [7:0] ln [3];
      logic [7:0] rn [3];
      logic [7:0] lcode, rcode;
      csh_res_t   res;
      w = clamp(width_reg, 3, LINE_MAX);
      h = clamp(height_reg, 3, ROWS_MAX);
      d = clamp(disp_reg, 1, DISP_MAX);
      r = row;
      c = col;
      if (c >= w) c = w - 1;
      if (r >= h) r = h - 1;
      top = r & 1;
      mid = (r + 1) & 1;
      ln = '{left_rows[top][c], left_rows[mid][c], lp};
      rn = '{right_rows[top][c], right_rows[mid][c], rp};
      left_rows[top][c]  = lp;
      right_rows[top][c] = rp;

      if (r >= 2 && c >= 1) begin
        j = c - 1;
        if (j == 0) begin
          right_codes[0] = '0;  // left border column
        end else begin
          lcode = census_code(left_win, ln);
          rcode = census_code(right_win, rn);
          maxk  = (j < d - 1) ? j : d - 1;
          right_codes[j % DISP_MAX] = rcode;
          for (k = 0; k <= maxk; k++) begin
            res.row  = 10'(r - 1);
            res.col  = 10'(j);
            res.disp = 6'(k);
            res.cost = 4'($countones(lcode ^ right_codes[(j - k) % DISP_MAX]));
            res.last = (k == maxk);
            pending_costs.push_back(res);
          end
        end
      end

      for (int i = 0; i < 3; i++) begin
        left_win[i]      = left_win[i + 3];
        left_win[i + 3]  = ln[i];
        right_win[i]     = right_win[i + 3];
        right_win[i + 3] = rn[i];
      end

      c++;
      if (c >= w) begin
        c = 0;
        r++;
        if (r >= h) r = 0;
      end
      row = r;
      col = c;
    endfunction

    function int outstanding();
      return pending_costs.size();
    endfunction

    function void flag(string field, int unsigned want, int unsigned got);
      errors++;
      if (errors <= MAX_REPORTS) $error("%s: expected %0d, actual %0d", field, want, got);
    endfunction

    function void check_cost(csh_res_t got);
      csh_res_t want;
      if (pending_costs.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $error("cost with none owed: row %0d column %0d disparity %0d",
                 got.row, got.col, got.disp);
        return;
      end
      want = pending_costs.pop_front();
      if (got.row !== want.row) flag("centre_row", want.row, got.row);
      if (got.col !== want.col) flag("centre_column", want.col, got.col);
      if (got.disp !== want.disp) flag("disparity", want.disp, got.disp);
      if (got.cost !== want.cost) flag("match_cost", want.cost, got.cost);
      if (got.last !== want.last) flag("last_of_pixel", want.last, got.last);
    endfunction
  endclass

endpackage

[tb/census_hamming_stereo_cost_top_test.sv]
// Testbench top for census_hamming_stereo_cost_top: drives pixel pairs and register
// writes over several image geometries and checks every cost transfer in order.
// Depends on csh_pkg, csh_cost_scoreboard_pkg and the block's RTL.
module census_hamming_stereo_cost_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import csh_pkg::*;
  import csh_cost_scoreboard_pkg::*;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int BUSY_CYCLES  = 8;
  localparam int TAIL_CYCLES  = 16;
  localparam int RANDOM_ITEMS = 64;
  localparam longint RUN_LIMIT_NS = 20_000_000;

  // two 3x3 frames; the centre is raster position 4 of each
  localparam logic [7:0] DIRECTED_LEFT [18] = '{
    8'd0,   8'd128, 8'd255, 8'd127, 8'd128, 8'd129, 8'd128, 8'd0,   8'd255,
    8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
  localparam logic [7:0] DIRECTED_RIGHT [18] = '{
    8'd255, 8'd0,   8'd128, 8'd128, 8'd128, 8'd128, 8'd1,   8'd254, 8'd128,
    8'd0,   8'd0,   8'd0,   8'd0,   8'd255, 8'd0,   8'd0,   8'd0,   8'd0};

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [10:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  left_pixel = '0;
  logic [7:0]  right_pixel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  centre_row;
  logic [9:0]  centre_column;
  logic [5:0]  disparity;
  logic [3:0]  match_cost;
  logic        last_of_pixel;

  bit steady = 1'b0;  // no idling on either side while set
  cost_scoreboard sb;

  census_hamming_stereo_cost_top DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .left_pixel   (left_pixel),
    .right_pixel  (right_pixel),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .centre_row   (centre_row),
    .centre_column(centre_column),
    .disparity    (disparity),
    .match_cost   (match_cost),
    .last_of_pixel(last_of_pixel)
  );

  always #5 clk = ~clk;

  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(3))
      0: return 8'($urandom);
      1: return $urandom_range(1) ? 8'hff : 8'h00;
      default: return 8'(126 + $urandom_range(4));  // near ties
    endcase
  endfunction

  // upper bits carry junk that the register drops
  function automatic logic [10:0] pick_disparities();
    logic [6:0] d;
    case ($urandom_range(5))
      0: d = 7'd0;
      1: d = 7'd1;
      2: d = 7'd2;
      3: d = 7'd127;
      4: d = 7'd64;
      default: d = 7'($urandom_range(63, 1));
    endcase
    return {4'($urandom), d};
  endfunction

  task automatic send_pixel(input logic [7:0] lp, input logic [7:0] rp);
    if (!steady) begin
      while ($urandom_range(99) < 17) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid    <= 1'b1;
    left_pixel  <= lp;
    right_pixel <= rp;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(lp, rp);
  endtask

  // all owed costs in, then time for a pixel that gives none to finish
  task automatic settle();
    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (BUSY_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [10:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
  endtask

  task automatic configure(input logic [10:0] w, input logic [10:0] h,
                           input logic [10:0] d);
    settle();
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_DISPARITIES, d);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_random(input int n);
    for (int i = 0; i < n; i++) send_pixel(pick_pixel(), pick_pixel());
  endtask

  // cost side: check each transfer, then choose ready for the next edge
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        sb.check_cost({centre_row, centre_column, disparity, match_cost, last_of_pixel});
      out_ready <= steady || ($urandom_range(99) >= 17);
    end
  end

  initial begin
    int n, sent, phase;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // reset geometry: row 0 only, no costs
    send_random(5);

    // below-range values clamp to a 3x3 image with one disparity
    configure(11'd0, 11'd1, 11'd0);
    for (int i = 0; i < 18; i++) begin
      if (i == 13) begin
        // unused index: no restart, the frame carries on
        settle();
        write_reg(REG_UNUSED, 11'($urandom));
        cfg_valid <= 1'b0;
      end
      send_pixel(DIRECTED_LEFT[i], DIRECTED_RIGHT[i]);
    end

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      n = $urandom_range(28, 16);
      steady = (phase == 2);
      configure(11'($urandom_range(9)), 11'($urandom_range(5)), pick_disparities());
      for (int i = 0; i < n; i++) begin
        if (phase == 1 && i == n / 2) begin
          in_valid <= 1'b0;
          do @(posedge clk); while (sb.outstanding() != 0);
        end
        send_pixel(pick_pixel(), pick_pixel());
      end
      sent += n;
      phase++;
    end
    steady = 1'b0;

    // tallest frame, narrowest rows, no idling
    steady = 1'b1;
    configure(11'd3, 11'd2047, pick_disparities());
    send_random(36);
    steady = 1'b0;

    in_valid <= 1'b0;
    do @(posedge clk); while (sb.outstanding() != 0);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("** census_hamming_stereo_cost_top: PASSED **");
    end else begin
      $display("** census_hamming_stereo_cost_top: FAILED **");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** census_hamming_stereo_cost_top: FAILED **");
    $finish;
  end

endmodule
